### rtl/core/mphm_pkg.sv
// ----------------------------------------------------------------------------
// mphm_pkg
// shared types, register indexes and constants of the memory pressure monitor
// ----------------------------------------------------------------------------
package mphm_pkg;

  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned MB_W       = 28;
  localparam int unsigned MB_SHIFT   = 20;
  localparam int unsigned SCORE_W    = 5;
  localparam int unsigned SEV_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned PCT_SCALE  = 100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAISE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUALIFY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RISING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXHAUSTED = 3'd5;

  // threshold slots of the product array
  localparam int unsigned TH_RAISE     = 0;
  localparam int unsigned TH_RELEASE   = 1;
  localparam int unsigned TH_RISING    = 2;
  localparam int unsigned TH_CRITICAL  = 3;
  localparam int unsigned TH_EXHAUSTED = 4;
  localparam int unsigned NUM_TH       = 5;

  localparam logic [PCT_W-1:0] RST_RAISE     = 7'd82;
  localparam logic [PCT_W-1:0] RST_RELEASE   = 7'd78;
  localparam logic [CNT_W-1:0] RST_QUALIFY   = 8'd3;
  localparam logic [PCT_W-1:0] RST_RISING    = 7'd85;
  localparam logic [PCT_W-1:0] RST_CRITICAL  = 7'd90;
  localparam logic [PCT_W-1:0] RST_EXHAUSTED = 7'd95;

  localparam logic [SCORE_W-1:0] SCORE_NONE      = 5'd0;
  localparam logic [SCORE_W-1:0] SCORE_ELEVATED  = 5'd15;
  localparam logic [SCORE_W-1:0] SCORE_RISING    = 5'd18;
  localparam logic [SCORE_W-1:0] SCORE_CRITICAL  = 5'd20;
  localparam logic [SCORE_W-1:0] SCORE_EXHAUSTED = 5'd24;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef enum logic [SEV_W-1:0] {
    SEV_NONE      = 3'd0,
    SEV_ELEVATED  = 3'd1,
    SEV_RISING    = 3'd2,
    SEV_CRITICAL  = 3'd3,
    SEV_EXHAUSTED = 3'd4
  } sev_e;

  typedef struct packed {
    logic [PCT_W-1:0] raise_pct;
    logic [PCT_W-1:0] rel_pct;
    logic [CNT_W-1:0] qualify_cnt;
    logic [PCT_W-1:0] rising_pct;
    logic [PCT_W-1:0] critical_pct;
    logic [PCT_W-1:0] exhaust_pct;
  } cfg_t;

  // first member lands in the top bits
  typedef struct packed {
    logic [MB_W-1:0]    total_mb;
    logic [MB_W-1:0]    used_mb;
    logic [SCORE_W-1:0] score;
    sev_e               severity;
    logic               finding_valid;
    logic               alarm_active;
    logic               sample_taken;
  } res_t;

  localparam int unsigned RES_W     = $bits(res_t);
  localparam int unsigned OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 8'd1;
  endfunction

endpackage

### rtl/core/mphm_regs.sv
// ----------------------------------------------------------------------------
// mphm_regs
// configuration registers written through the plain write port
// ----------------------------------------------------------------------------
module mphm_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mphm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mphm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output mphm_pkg::cfg_t                     cfg_o
);

  mphm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mphm_pkg::CFG_RAISE:     cfg_d.raise_pct    = cfg_wdata_i[mphm_pkg::PCT_W-1:0];
        mphm_pkg::CFG_RELEASE:   cfg_d.rel_pct      = cfg_wdata_i[mphm_pkg::PCT_W-1:0];
        mphm_pkg::CFG_QUALIFY:   cfg_d.qualify_cnt  = cfg_wdata_i[mphm_pkg::CNT_W-1:0];
        mphm_pkg::CFG_RISING:    cfg_d.rising_pct   = cfg_wdata_i[mphm_pkg::PCT_W-1:0];
        mphm_pkg::CFG_CRITICAL:  cfg_d.critical_pct = cfg_wdata_i[mphm_pkg::PCT_W-1:0];
        mphm_pkg::CFG_EXHAUSTED: cfg_d.exhaust_pct  = cfg_wdata_i[mphm_pkg::PCT_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raise_pct    <= mphm_pkg::RST_RAISE;
      cfg_q.rel_pct      <= mphm_pkg::RST_RELEASE;
      cfg_q.qualify_cnt  <= mphm_pkg::RST_QUALIFY;
      cfg_q.rising_pct   <= mphm_pkg::RST_RISING;
      cfg_q.critical_pct <= mphm_pkg::RST_CRITICAL;
      cfg_q.exhaust_pct  <= mphm_pkg::RST_EXHAUSTED;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/mphm_scale.sv
// ----------------------------------------------------------------------------
// mphm_scale
// input stage: registers the scaled usage and the threshold products
// ----------------------------------------------------------------------------
module mphm_scale #(
  parameter int unsigned BYTE_WIDTH = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mphm_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [BYTE_WIDTH-1:0]             used_i,
  input  logic [BYTE_WIDTH-1:0]             total_i,
  input  logic                              take_i,
  output logic                              valid_o,
  output logic [BYTE_WIDTH+6:0]             prod_used_o,
  output logic [BYTE_WIDTH+6:0]             prod_th_o [mphm_pkg::NUM_TH],
  output logic                              taken_o,
  output logic [mphm_pkg::MB_W-1:0]         used_mb_o,
  output logic [mphm_pkg::MB_W-1:0]         total_mb_o
);

  localparam int unsigned PW = BYTE_WIDTH + mphm_pkg::PCT_W;
  localparam int unsigned XW = BYTE_WIDTH + mphm_pkg::MB_W;

  logic                valid_q;
  logic                load;
  logic [PW-1:0]       prod_used_q;
  logic [PW-1:0]       prod_th_q [mphm_pkg::NUM_TH];
  logic [mphm_pkg::PCT_W-1:0] pct [mphm_pkg::NUM_TH];
  logic                taken_q;
  logic [mphm_pkg::MB_W-1:0] used_mb_q, total_mb_q;
  logic [XW-1:0]       used_x, total_x;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  assign pct[mphm_pkg::TH_RAISE]     = cfg_i.raise_pct;
  assign pct[mphm_pkg::TH_RELEASE]   = cfg_i.rel_pct;
  assign pct[mphm_pkg::TH_RISING]    = cfg_i.rising_pct;
  assign pct[mphm_pkg::TH_CRITICAL]  = cfg_i.critical_pct;
  assign pct[mphm_pkg::TH_EXHAUSTED] = cfg_i.exhaust_pct;

  assign used_x  = {{mphm_pkg::MB_W{1'b0}}, used_i};
  assign total_x = {{mphm_pkg::MB_W{1'b0}}, total_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_used_q <= PW'(used_i) * PW'(mphm_pkg::PCT_SCALE);
      for (int k = 0; k < mphm_pkg::NUM_TH; k++) begin
        prod_th_q[k] <= PW'(pct[k]) * PW'(total_i);
      end
      taken_q    <= (total_i != '0);
      used_mb_q  <= used_x[mphm_pkg::MB_SHIFT +: mphm_pkg::MB_W];
      total_mb_q <= total_x[mphm_pkg::MB_SHIFT +: mphm_pkg::MB_W];
    end
  end

  assign valid_o     = valid_q;
  assign prod_used_o = prod_used_q;
  assign prod_th_o   = prod_th_q;
  assign taken_o     = taken_q;
  assign used_mb_o   = used_mb_q;
  assign total_mb_o  = total_mb_q;

endmodule

### rtl/core/mphm_eval.sv
// ----------------------------------------------------------------------------
// mphm_eval
// threshold compare, hysteresis state update, band select and result register
// ----------------------------------------------------------------------------
module mphm_eval #(
  parameter int unsigned BYTE_WIDTH = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mphm_pkg::cfg_t                    cfg_i,
  input  logic                              valid_i,
  output logic                              take_o,
  input  logic [BYTE_WIDTH+6:0]             prod_used_i,
  input  logic [BYTE_WIDTH+6:0]             prod_th_i [mphm_pkg::NUM_TH],
  input  logic                              taken_i,
  input  logic [mphm_pkg::MB_W-1:0]         used_mb_i,
  input  logic [mphm_pkg::MB_W-1:0]         total_mb_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mphm_pkg::res_t                    res_o
);

  logic                       out_valid_q;
  mphm_pkg::res_t             res_q, res_d;
  logic                       alarm_q, alarm_d;
  logic [mphm_pkg::CNT_W-1:0] high_q, high_d, low_q, low_d;
  logic [mphm_pkg::CNT_W-1:0] high_inc, low_inc;
  logic [mphm_pkg::NUM_TH-1:0] ge;
  logic                       report;
  logic                       move;

  assign take_o = !out_valid_q || out_ready_i;
  assign move   = valid_i && take_o;

  always_comb begin
    for (int k = 0; k < mphm_pkg::NUM_TH; k++) begin
      ge[k] = (prod_used_i >= prod_th_i[k]);
    end
  end

  assign high_inc = mphm_pkg::sat_inc(high_q);
  assign low_inc  = mphm_pkg::sat_inc(low_q);

  always_comb begin
    alarm_d = alarm_q;
    high_d  = high_q;
    low_d   = low_q;
    report  = 1'b0;
    res_d   = '0;
    if (taken_i) begin
      if (!alarm_q) begin
        if (ge[mphm_pkg::TH_RAISE]) begin
          high_d = high_inc;
          if (high_inc >= cfg_i.qualify_cnt) begin
            alarm_d = 1'b1;
            low_d   = '0;
            report  = 1'b1;
          end
        end else begin
          high_d = '0;
        end
      end else begin
        report = 1'b1;
        if (!ge[mphm_pkg::TH_RELEASE]) begin
          low_d = low_inc;
          if (low_inc >= cfg_i.qualify_cnt) begin
            alarm_d = 1'b0;
            high_d  = '0;
            report  = 1'b0;
          end
        end else begin
          low_d = '0;
        end
      end

      if (report) begin
        priority if (ge[mphm_pkg::TH_EXHAUSTED]) begin
          res_d.severity = mphm_pkg::SEV_EXHAUSTED;
          res_d.score    = mphm_pkg::SCORE_EXHAUSTED;
        end else if (ge[mphm_pkg::TH_CRITICAL]) begin
          res_d.severity = mphm_pkg::SEV_CRITICAL;
          res_d.score    = mphm_pkg::SCORE_CRITICAL;
        end else if (ge[mphm_pkg::TH_RISING]) begin
          res_d.severity = mphm_pkg::SEV_RISING;
          res_d.score    = mphm_pkg::SCORE_RISING;
        end else if (ge[mphm_pkg::TH_RAISE]) begin
          res_d.severity = mphm_pkg::SEV_ELEVATED;
          res_d.score    = mphm_pkg::SCORE_ELEVATED;
        end else begin
          res_d.severity = mphm_pkg::SEV_NONE;
          res_d.score    = mphm_pkg::SCORE_NONE;
        end
      end
      res_d.sample_taken  = 1'b1;
      res_d.finding_valid = (res_d.severity != mphm_pkg::SEV_NONE);
      res_d.used_mb       = used_mb_i;
      res_d.total_mb      = total_mb_i;
    end
    res_d.alarm_active = alarm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      alarm_q     <= 1'b0;
      high_q      <= '0;
      low_q       <= '0;
    end else begin
      if (take_o) begin
        out_valid_q <= valid_i;
      end
      if (move) begin
        alarm_q <= alarm_d;
        high_q  <= high_d;
        low_q   <= low_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // state only moves with a transaction
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> ($stable(alarm_q) && $stable(high_q) && $stable(low_q)))
    else $error("hysteresis state changed without a transaction");

  // a finding is reported only while the alarm is on
  a_finding_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.finding_valid) |-> res_q.alarm_active)
    else $error("finding reported with alarm off");

  // finding flag and score agree
  a_score_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.finding_valid == (res_q.score != mphm_pkg::SCORE_NONE)))
    else $error("score does not match finding flag");

  // ignored sample reports nothing
  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.sample_taken) |-> (!res_q.finding_valid && res_q.used_mb == '0))
    else $error("ignored sample carries a finding or size");

  // result tracks the alarm register
  a_alarm_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> (res_q.alarm_active == alarm_q))
    else $error("reported alarm differs from alarm state");

endmodule

### rtl/core/memory_pressure_hysteresis_monitor_core.sv
// ----------------------------------------------------------------------------
// memory_pressure_hysteresis_monitor_core
// memory pressure alarm with hysteresis, qualify count and severity bands
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is taken and returns one
// result per sample, in order. The first register stage holds the usage
// scaled by 100 and the five threshold products (percent times total); the
// second compares them, steps the alarm and streak counters and registers
// the result. A stage advances when the next can take its data, so a full
// pipeline sustains one transaction per cycle while the output is taken.
// Usage compares are exact integer cross-multiplications. The user must write
// configuration through the plain port while no sample is in flight; unenforced.
module memory_pressure_hysteresis_monitor_core #(
  parameter int unsigned BYTE_WIDTH = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mphm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mphm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // used_bytes, total_bytes
  input  logic [((2*BYTE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // sample_taken, alarm_active, finding_valid, severity, score, used_mb, total_mb
  output logic [mphm_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  localparam int unsigned PW = BYTE_WIDTH + mphm_pkg::PCT_W;

  mphm_pkg::cfg_t            cfg;
  mphm_pkg::res_t            res;
  logic                      take;
  logic                      mid_valid;
  logic [PW-1:0]             prod_used;
  logic [PW-1:0]             prod_th [mphm_pkg::NUM_TH];
  logic                      taken;
  logic [mphm_pkg::MB_W-1:0] used_mb, total_mb;

  mphm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mphm_scale #(
    .BYTE_WIDTH (BYTE_WIDTH)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .used_i      (s_axis_tdata[BYTE_WIDTH-1:0]),
    .total_i     (s_axis_tdata[2*BYTE_WIDTH-1:BYTE_WIDTH]),
    .take_i      (take),
    .valid_o     (mid_valid),
    .prod_used_o (prod_used),
    .prod_th_o   (prod_th),
    .taken_o     (taken),
    .used_mb_o   (used_mb),
    .total_mb_o  (total_mb)
  );

  mphm_eval #(
    .BYTE_WIDTH (BYTE_WIDTH)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (mid_valid),
    .take_o      (take),
    .prod_used_i (prod_used),
    .prod_th_i   (prod_th),
    .taken_i     (taken),
    .used_mb_i   (used_mb),
    .total_mb_i  (total_mb),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {{(mphm_pkg::OUT_DATA_W - mphm_pkg::RES_W){1'b0}}, res};

endmodule
